[design/jmsp_pkg.sv]
// shared types, codes and helpers of the jpeg marker segment parser
`timescale 1ns / 1ps

package jmsp_pkg;

    localparam int MAX_FILL_BYTES = 6;
    localparam int FILL_W         = $clog2(MAX_FILL_BYTES + 1);

    localparam logic [7:0] BYTE_FILL   = 8'hFF;
    localparam logic [7:0] CODE_SOI    = 8'hD8;
    localparam logic [7:0] CODE_SOS    = 8'hDA;
    localparam logic [7:0] CODE_EOI    = 8'hD9;
    localparam logic [7:0] COMP_COLOR  = 8'd3;
    localparam logic [15:0] LEN_MIN    = 16'd2;
    localparam logic [15:0] LEN_FRAME  = 16'd8;

    localparam logic [2:0] ST_BUSY      = 3'd0;
    localparam logic [2:0] ST_SCAN      = 3'd1;
    localparam logic [2:0] ST_NOT_JPEG  = 3'd2;
    localparam logic [2:0] ST_FILL      = 3'd3;
    localparam logic [2:0] ST_BAD_LEN   = 3'd4;
    localparam logic [2:0] ST_NO_IMAGE  = 3'd5;
    localparam logic [2:0] ST_TRUNCATED = 3'd6;

    localparam logic [15:0] OFF_HEIGHT_HI = 16'd3;
    localparam logic [15:0] OFF_HEIGHT_LO = 16'd4;
    localparam logic [15:0] OFF_WIDTH_HI  = 16'd5;
    localparam logic [15:0] OFF_WIDTH_LO  = 16'd6;
    localparam logic [15:0] OFF_COMPS     = 16'd7;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] image_height;
        logic [15:0] image_width;
        logic        is_color;
        logic [7:0]  frame_marker;
    } t_result;

    function automatic logic is_frame_code(input logic [7:0] code);
        logic res;
        res = (code[7:4] == 4'hC) && (code[1:0] != 2'b00 || code[3:2] == 2'b00);
        return res;
    endfunction

endpackage

[design/jpeg_marker_segment_parser_core.sv]
// Top level of the jpeg marker segment parser. One file byte enters per beat
// and each byte yields one result beat carrying the running status and the
// frame values held so far; the parser keeps taking a byte every cycle as
// long as the result register is free or being drained in the same cycle.
// The result register is the only stage between the byte state machine and
// the output, so a result appears in the cycle after its byte is taken.
// Assert restart with the first byte of each new file; a final status is
// held until then.
`timescale 1ns / 1ps

module jpeg_marker_segment_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_restart,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_file,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_image_height,
    output logic [15:0] o_image_width,
    output logic        o_is_color,
    output logic [7:0]  o_frame_marker
);
    import jmsp_pkg::*;

    logic    accept;
    t_result next_res;
    t_result r_res;
    logic    r_out_valid;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    jmsp_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_restart     (i_restart),
        .i_data_byte   (i_data_byte),
        .i_end_of_file (i_end_of_file),
        .o_next        (next_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= next_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_res.status;
    assign o_image_height = r_res.image_height;
    assign o_image_width  = r_res.image_width;
    assign o_is_color     = r_res.is_color;
    assign o_frame_marker = r_res.frame_marker;

endmodule

[design/jmsp_parser.sv]
// byte-wise marker segment state machine, one byte per beat
`timescale 1ns / 1ps

module jmsp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_restart,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_file,
    output jmsp_pkg::t_result o_next
);
    import jmsp_pkg::*;

    typedef enum logic [2:0] {
        PH_START_FF,
        PH_START_D8,
        PH_MARKER,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_DONE
    } t_phase;

    t_phase              r_phase, c_phase, n_phase;
    logic [FILL_W-1:0]   r_fill, c_fill, n_fill;
    logic [7:0]          r_marker, c_marker, n_marker;
    logic [7:0]          r_len_high, c_len_high, n_len_high;
    logic [15:0]         r_seg_len, c_seg_len, n_seg_len;
    logic [15:0]         r_offset, c_offset, n_offset;
    logic [15:0]         r_height, c_height, n_height;
    logic [15:0]         r_width, c_width, n_width;
    logic                r_color, c_color, n_color;
    logic [7:0]          r_frame, c_frame, n_frame;
    logic [2:0]          r_status, c_status, n_status;
    logic [15:0]         r_cap_height, n_cap_height;
    logic [15:0]         r_cap_width, n_cap_width;
    logic                r_cap_color, n_cap_color;
    logic [15:0]         len_word;
    logic                frame_seg;
    logic                last_byte;

    always_comb begin
        c_phase    = i_restart ? PH_START_FF : r_phase;
        c_fill     = i_restart ? '0 : r_fill;
        c_marker   = i_restart ? 8'd0 : r_marker;
        c_len_high = i_restart ? 8'd0 : r_len_high;
        c_seg_len  = i_restart ? 16'd0 : r_seg_len;
        c_offset   = i_restart ? 16'd0 : r_offset;
        c_height   = i_restart ? 16'd0 : r_height;
        c_width    = i_restart ? 16'd0 : r_width;
        c_color    = i_restart ? 1'b0 : r_color;
        c_frame    = i_restart ? 8'd0 : r_frame;
        c_status   = i_restart ? ST_BUSY : r_status;

        n_phase      = c_phase;
        n_fill       = c_fill;
        n_marker     = c_marker;
        n_len_high   = c_len_high;
        n_seg_len    = c_seg_len;
        n_offset     = c_offset;
        n_height     = c_height;
        n_width      = c_width;
        n_color      = c_color;
        n_frame      = c_frame;
        n_status     = c_status;
        n_cap_height = r_cap_height;
        n_cap_width  = r_cap_width;
        n_cap_color  = r_cap_color;

        len_word  = {c_len_high, i_data_byte};
        frame_seg = is_frame_code(c_marker);
        last_byte = ({1'b0, c_offset} + 17'd1) >= {1'b0, c_seg_len};

        if (c_phase != PH_DONE) begin
            if (i_end_of_file) begin
                n_status = ST_TRUNCATED;
                n_phase  = PH_DONE;
            end else begin
                case (c_phase)
                    PH_START_FF: begin
                        if (i_data_byte == BYTE_FILL) begin
                            n_phase = PH_START_D8;
                        end else begin
                            n_status = ST_NOT_JPEG;
                            n_phase  = PH_DONE;
                        end
                    end
                    PH_START_D8: begin
                        if (i_data_byte == CODE_SOI) begin
                            n_fill  = '0;
                            n_phase = PH_MARKER;
                        end else begin
                            n_status = ST_NOT_JPEG;
                            n_phase  = PH_DONE;
                        end
                    end
                    PH_MARKER: begin
                        if (i_data_byte == BYTE_FILL) begin
                            if (c_fill >= FILL_W'(MAX_FILL_BYTES)) begin
                                n_status = ST_FILL;
                                n_phase  = PH_DONE;
                            end else begin
                                n_fill = c_fill + FILL_W'(1);
                            end
                        end else begin
                            n_marker = i_data_byte;
                            n_phase  = PH_LEN_HI;
                        end
                    end
                    PH_LEN_HI: begin
                        n_len_high = i_data_byte;
                        n_phase    = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        n_seg_len = len_word;
                        if (len_word < LEN_MIN) begin
                            n_status = ST_BAD_LEN;
                            n_phase  = PH_DONE;
                        end else if (c_marker == CODE_SOS) begin
                            n_status = ST_SCAN;
                            n_phase  = PH_DONE;
                        end else if (c_marker == CODE_EOI) begin
                            n_status = ST_NO_IMAGE;
                            n_phase  = PH_DONE;
                        end else if (len_word == LEN_MIN) begin
                            if (frame_seg) begin
                                n_frame = c_marker;
                            end
                            n_fill  = '0;
                            n_phase = PH_MARKER;
                        end else begin
                            n_offset = LEN_MIN;
                            n_phase  = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        case (c_offset)
                            OFF_HEIGHT_HI: n_cap_height = {i_data_byte, r_cap_height[7:0]};
                            OFF_HEIGHT_LO: n_cap_height = {r_cap_height[15:8], i_data_byte};
                            OFF_WIDTH_HI:  n_cap_width  = {i_data_byte, r_cap_width[7:0]};
                            OFF_WIDTH_LO:  n_cap_width  = {r_cap_width[15:8], i_data_byte};
                            OFF_COMPS:     n_cap_color  = (i_data_byte == COMP_COLOR);
                            default:       n_cap_color  = r_cap_color;
                        endcase
                        if (last_byte) begin
                            if (frame_seg) begin
                                if (c_seg_len >= LEN_FRAME) begin
                                    n_height = n_cap_height;
                                    n_width  = n_cap_width;
                                    n_color  = n_cap_color;
                                end
                                n_frame = c_marker;
                            end
                            n_fill  = '0;
                            n_phase = PH_MARKER;
                        end else begin
                            n_offset = c_offset + 16'd1;
                        end
                    end
                    default: begin
                        n_status = ST_TRUNCATED;
                        n_phase  = PH_DONE;
                    end
                endcase
            end
        end

        o_next.status       = n_status;
        o_next.image_height = n_height;
        o_next.image_width  = n_width;
        o_next.is_color     = n_color;
        o_next.frame_marker = n_frame;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_START_FF;
            r_fill     <= '0;
            r_marker   <= 8'd0;
            r_len_high <= 8'd0;
            r_seg_len  <= 16'd0;
            r_offset   <= 16'd0;
            r_height   <= 16'd0;
            r_width    <= 16'd0;
            r_color    <= 1'b0;
            r_frame    <= 8'd0;
            r_status   <= ST_BUSY;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_fill     <= n_fill;
            r_marker   <= n_marker;
            r_len_high <= n_len_high;
            r_seg_len  <= n_seg_len;
            r_offset   <= n_offset;
            r_height   <= n_height;
            r_width    <= n_width;
            r_color    <= n_color;
            r_frame    <= n_frame;
            r_status   <= n_status;
        end
    end

    // values caught mid-segment, only committed once the segment is complete
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_cap_height <= n_cap_height;
            r_cap_width  <= n_cap_width;
            r_cap_color  <= n_cap_color;
        end
    end

endmodule
